// ===== hdl/clsf_pkg.sv =====
// Shared types and codes for the control link session filter.
`timescale 1ns / 1ps

package clsf_pkg;

  // Packet type codes
  localparam logic [3:0] PT_CONNREQ   = 4'd0;
  localparam logic [3:0] PT_CONNACK   = 4'd1;
  localparam logic [3:0] PT_CONFIRM   = 4'd2;
  localparam logic [3:0] PT_HEARTBEAT = 4'd3;
  localparam logic [3:0] PT_ESTOP     = 4'd4;
  localparam logic [3:0] PT_MODE      = 4'd5;
  localparam logic [3:0] PT_DOF       = 4'd6;
  localparam logic [3:0] PT_STATUS    = 4'd7;
  localparam logic [3:0] PT_ACK       = 4'd8;

  // Reply kinds
  localparam logic [1:0] SK_NONE    = 2'd0;
  localparam logic [1:0] SK_ACK     = 2'd1;
  localparam logic [1:0] SK_CONNACK = 2'd2;

  // Acknowledgement codes
  localparam logic [2:0] AC_OK      = 3'd0;
  localparam logic [2:0] AC_BADSESS = 3'd1;
  localparam logic [2:0] AC_BADFMT  = 3'd2;
  localparam logic [2:0] AC_SEQOLD  = 3'd3;
  localparam logic [2:0] AC_UNSUP   = 3'd4;

  // Event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_ESTABLISHED = 3'd1;
  localparam logic [2:0] EV_ESTOP       = 3'd2;
  localparam logic [2:0] EV_SET_MODE    = 3'd3;
  localparam logic [2:0] EV_SET_DOF     = 3'd4;

  // Configuration register indexes
  localparam int          CFG_IDX_W               = 3;
  localparam int          CFG_DATA_W              = 16;
  localparam logic [2:0]  CFG_STRICT_SESSION      = 3'd0;
  localparam logic [2:0]  CFG_REQUIRE_SESSION     = 3'd1;
  localparam logic [2:0]  CFG_CONNECT_REQ_LEN     = 3'd2;
  localparam logic [2:0]  CFG_CONNECT_CONFIRM_LEN = 3'd3;
  localparam logic [2:0]  CFG_ESTOP_LEN           = 3'd4;
  localparam logic [2:0]  CFG_SET_MODE_LEN        = 3'd5;
  localparam logic [2:0]  CFG_SET_DOF_LEN         = 3'd6;

  typedef struct packed {
    logic [3:0]  packet_type;
    logic        ack_requested;
    logic [31:0] packet_seq;
    logic [63:0] packet_session;
    logic [15:0] payload_length;
    logic [63:0] payload_word;
    logic [63:0] fresh_nonce;
    logic [63:0] fresh_session;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [2:0]  ack_code;
    logic [31:0] acked_seq;
    logic [31:0] reply_seq;
    logic [63:0] reply_session;
    logic [63:0] peer_nonce_echo;
    logic [63:0] local_nonce_out;
    logic [2:0]  event_kind;
    logic        estop_active;
    logic        session_up;
  } rslt_t;

  typedef struct packed {
    logic        sess_id_check;
    logic        cmds_need_link;
    logic [15:0] connect_req_length;
    logic [15:0] connect_confirm_length;
    logic [15:0] estop_length;
    logic [15:0] set_mode_length;
    logic [15:0] set_dof_length;
  } cfg_t;

  typedef struct packed {
    logic [63:0] session_value;
    logic [63:0] peer_nonce;
    logic [63:0] local_nonce;
    logic        established_flag;
    logic [31:0] last_command_seq;
    logic [31:0] transmit_seq;
    logic        estop_flag;
  } sess_state_t;

endpackage

// ===== hdl/clsf_cfg_regs.sv =====
// Configuration register file of the control link session filter.
`timescale 1ns / 1ps

module clsf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [clsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output clsf_pkg::cfg_t                 cfg
);

  clsf_pkg::cfg_t cfg_r;
  clsf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        clsf_pkg::CFG_STRICT_SESSION:      cfg_nxt.sess_id_check = cfg_wdata[0];
        clsf_pkg::CFG_REQUIRE_SESSION:     cfg_nxt.cmds_need_link = cfg_wdata[0];
        clsf_pkg::CFG_CONNECT_REQ_LEN:     cfg_nxt.connect_req_length = cfg_wdata;
        clsf_pkg::CFG_CONNECT_CONFIRM_LEN: cfg_nxt.connect_confirm_length = cfg_wdata;
        clsf_pkg::CFG_ESTOP_LEN:           cfg_nxt.estop_length = cfg_wdata;
        clsf_pkg::CFG_SET_MODE_LEN:        cfg_nxt.set_mode_length = cfg_wdata;
        clsf_pkg::CFG_SET_DOF_LEN:         cfg_nxt.set_dof_length = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sess_id_check          <= 1'b1;
      cfg_r.cmds_need_link         <= 1'b1;
      cfg_r.connect_req_length     <= 16'd8;
      cfg_r.connect_confirm_length <= 16'd8;
      cfg_r.estop_length           <= 16'd1;
      cfg_r.set_mode_length        <= 16'd1;
      cfg_r.set_dof_length         <= 16'd24;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/clsf_decide.sv =====
// Per-packet decision logic: session, sequence and length checks and reply build.
`timescale 1ns / 1ps

module clsf_decide (
  input  clsf_pkg::pkt_t        pkt,
  input  clsf_pkg::cfg_t        cfg,
  input  clsf_pkg::sess_state_t st,
  output clsf_pkg::sess_state_t st_nxt,
  output clsf_pkg::rslt_t       res
);

  logic        handshake;
  logic        command;
  logic        sess_ok;
  logic        sess_fail;
  logic        ack_en;
  logic [2:0]  code;
  logic [2:0]  ev;
  logic [15:0] need_len;

  assign handshake = (pkt.packet_type <= clsf_pkg::PT_CONFIRM);
  assign command   = pkt.packet_type inside {clsf_pkg::PT_ESTOP, clsf_pkg::PT_MODE,
                                             clsf_pkg::PT_DOF};
  // A zero session value means no session, so it never matches.
  assign sess_ok   = (st.session_value != 64'd0) &&
                     (pkt.packet_session == st.session_value);
  assign sess_fail = !handshake && cfg.sess_id_check &&
                     !((pkt.packet_type == clsf_pkg::PT_HEARTBEAT) &&
                       (pkt.packet_session == 64'd0)) &&
                     !sess_ok;

  always_comb begin
    case (pkt.packet_type)
      clsf_pkg::PT_ESTOP: need_len = cfg.estop_length;
      clsf_pkg::PT_MODE:  need_len = cfg.set_mode_length;
      default:            need_len = cfg.set_dof_length;
    endcase
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    ack_en = 1'b0;
    code   = clsf_pkg::AC_OK;
    ev     = clsf_pkg::EV_NONE;

    if (sess_fail) begin
      ack_en = 1'b1;
      code   = clsf_pkg::AC_BADSESS;
    end else if (command && (pkt.packet_seq <= st.last_command_seq)) begin
      ack_en = 1'b1;
      code   = clsf_pkg::AC_SEQOLD;
    end else begin
      // The sequence number is recorded even if a later check rejects the command.
      if (command) begin
        st_nxt.last_command_seq = pkt.packet_seq;
      end
      case (pkt.packet_type)
        clsf_pkg::PT_CONNREQ: begin
          if (pkt.payload_length != cfg.connect_req_length) begin
            ack_en = 1'b1;
            code   = clsf_pkg::AC_BADFMT;
          end else begin
            st_nxt.peer_nonce       = pkt.payload_word;
            st_nxt.local_nonce      = pkt.fresh_nonce;
            st_nxt.session_value    = pkt.fresh_session;
            st_nxt.established_flag = 1'b0;
            st_nxt.last_command_seq = 32'd0;
            st_nxt.transmit_seq     = st.transmit_seq + 32'd1;
            res.send_kind           = clsf_pkg::SK_CONNACK;
            res.reply_seq           = st.transmit_seq;
            res.reply_session       = pkt.fresh_session;
            res.peer_nonce_echo     = pkt.payload_word;
            res.local_nonce_out     = pkt.fresh_nonce;
          end
        end
        clsf_pkg::PT_CONFIRM: begin
          ack_en = 1'b1;
          if (!sess_ok) begin
            code = clsf_pkg::AC_BADSESS;
          end else if ((pkt.payload_length != cfg.connect_confirm_length) ||
                       (pkt.payload_word != st.local_nonce)) begin
            code = clsf_pkg::AC_BADFMT;
          end else begin
            if (!st.established_flag) begin
              ev = clsf_pkg::EV_ESTABLISHED;
            end
            st_nxt.established_flag = 1'b1;
          end
        end
        clsf_pkg::PT_HEARTBEAT: begin
          ack_en = 1'b1;
        end
        clsf_pkg::PT_ESTOP, clsf_pkg::PT_MODE, clsf_pkg::PT_DOF: begin
          ack_en = 1'b1;
          if (cfg.cmds_need_link && !st.established_flag) begin
            code = clsf_pkg::AC_BADSESS;
          end else if (pkt.payload_length != need_len) begin
            code = clsf_pkg::AC_BADFMT;
          end else if (pkt.packet_type == clsf_pkg::PT_ESTOP) begin
            st_nxt.estop_flag = (pkt.payload_word != 64'd0);
            ev                = clsf_pkg::EV_ESTOP;
          end else if (pkt.packet_type == clsf_pkg::PT_MODE) begin
            ev = clsf_pkg::EV_SET_MODE;
          end else begin
            ev = clsf_pkg::EV_SET_DOF;
          end
        end
        clsf_pkg::PT_ACK: ;
        default: begin
          ack_en = 1'b1;
          code   = clsf_pkg::AC_UNSUP;
        end
      endcase
    end

    // An ack only goes out when the sender asked for one.
    if (ack_en && pkt.ack_requested) begin
      res.send_kind       = clsf_pkg::SK_ACK;
      res.ack_code        = code;
      res.acked_seq       = pkt.packet_seq;
      res.reply_seq       = st.transmit_seq;
      res.reply_session   = st.session_value;
      st_nxt.transmit_seq = st.transmit_seq + 32'd1;
    end

    res.event_kind   = ev;
    res.estop_active = st_nxt.estop_flag;
    res.session_up   = st_nxt.established_flag;
  end

endmodule

// ===== hdl/control_link_session_filter.sv =====
// Top level of the control link session filter: handshake stages and session state.
`timescale 1ns / 1ps

// Each accepted header gives exactly one reply descriptor. The block takes one header
// per cycle while the output side is not stalled: a header is held in an input
// register, decided by a single pass of compare logic against the registered session
// state, and its descriptor is then loaded into an output register when the output
// side is not stalled. The session state is updated on the same edge that loads the
// output register, so each header sees everything its predecessors left behind. A
// stall on the output side holds the result and backs up into in_stall once the input
// register is also full. Configuration writes take effect on the next edge and should
// be made only while no header is in flight.
module control_link_session_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  clsf_pkg::pkt_t                  in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output clsf_pkg::rslt_t                 out_item,
  input  logic                            cfg_we,
  input  logic [clsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clsf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  clsf_pkg::cfg_t        cfg;
  clsf_pkg::pkt_t        s1_item_r;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  clsf_pkg::rslt_t       out_item_r;
  clsf_pkg::rslt_t       res;
  clsf_pkg::sess_state_t st_r;
  clsf_pkg::sess_state_t st_nxt;
  logic                  adv;
  logic                  in_xfer;

  clsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  clsf_decide u_decide (
    .pkt    (s1_item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // The decided item moves on when the output register is empty or being drained.
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{session_value:    64'd0,
                       peer_nonce:       64'd0,
                       local_nonce:      64'd0,
                       established_flag: 1'b0,
                       last_command_seq: 32'd0,
                       transmit_seq:     32'd1,
                       estop_flag:       1'b0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // A full pipeline with a stalled output must push back on the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while both stages are held");

  // Every reply sent consumes exactly one transmit sequence number.
  a_tx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.send_kind != clsf_pkg::SK_NONE)) |=>
      (st_r.transmit_seq == $past(st_r.transmit_seq) + 32'd1))
    else $error("transmit sequence did not advance with a reply");

  // A reply's sequence number is the counter value before the transfer.
  a_reply_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.send_kind != clsf_pkg::SK_NONE)) |=>
      (out_item_r.reply_seq == $past(st_r.transmit_seq)))
    else $error("reply carries the wrong transmit sequence number");

  // The reported flags match the state left behind by the item.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> ((out_item_r.session_up == st_r.established_flag) &&
             (out_item_r.estop_active == st_r.estop_flag)))
    else $error("reported flags disagree with session state");
`endif

endmodule
